[src/cisph_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cisph_pkg
// shared constants, operation codes and types for the crossing histogram
// ----------------------------------------------------------------------------
package cisph_pkg;

   localparam int VALUE_BITS_DEF = 8;
   localparam int NUM_BINS_DEF   = 256;
   localparam int COUNT_BITS_DEF = 32;

   localparam int OP_BITS        = 2;
   localparam int CORNER_BITS    = 8;
   localparam int BIN_BITS       = 8;
   localparam int OUT_COUNT_BITS = 32;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [OP_BITS-1:0] OP_ADD   = 2'd0;
   localparam logic [OP_BITS-1:0] OP_READ  = 2'd1;
   localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd2;

   typedef struct packed {
      logic [OP_BITS-1:0]  op;
      logic [BIN_BITS-1:0] lo;
      logic [BIN_BITS-1:0] hi;
      logic [BIN_BITS-1:0] sel;
      logic                sel_ok;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_ADD,
      BK_READ,
      BK_RESULT
   } back_state_type;

endpackage

[src/cisph_intf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cisph_req_if / cisph_rsp_if
// valid/ready channels for command beats and bin count beats
// ----------------------------------------------------------------------------
interface cisph_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [cisph_pkg::OP_BITS-1:0]        operation;
   logic [cisph_pkg::CORNER_BITS-1:0]    corner_a;
   logic [cisph_pkg::CORNER_BITS-1:0]    corner_b;
   logic [cisph_pkg::CORNER_BITS-1:0]    corner_c;
   logic [cisph_pkg::CORNER_BITS-1:0]    corner_d;
   logic [cisph_pkg::CORNER_BITS-1:0]    corner_e;
   logic [cisph_pkg::CORNER_BITS-1:0]    corner_f;
   logic [cisph_pkg::CORNER_BITS-1:0]    corner_g;
   logic [cisph_pkg::CORNER_BITS-1:0]    corner_h;
   logic [cisph_pkg::BIN_BITS-1:0]       bin_select;

   modport source (output valid, operation, corner_a, corner_b, corner_c, corner_d,
                   corner_e, corner_f, corner_g, corner_h, bin_select, input ready);
   modport sink   (input valid, operation, corner_a, corner_b, corner_c, corner_d,
                   corner_e, corner_f, corner_g, corner_h, bin_select, output ready);
endinterface

interface cisph_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [cisph_pkg::BIN_BITS-1:0]       bin_number;
   logic [cisph_pkg::OUT_COUNT_BITS-1:0] bin_count;

   modport source (output valid, bin_number, bin_count, input ready);
   modport sink   (input valid, bin_number, bin_count, output ready);
endinterface

[src/cisph_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cisph_ram
// simple dual port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module cisph_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/cisph_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cisph_front
// takes command beats, finds the corner span and drops empty work
// ----------------------------------------------------------------------------
module cisph_front #(
   parameter int VALUE_BITS = cisph_pkg::VALUE_BITS_DEF,
   parameter int NUM_BINS   = cisph_pkg::NUM_BINS_DEF
) (
   cisph_req_if.sink          req_if,
   input  logic               q_full,
   input  logic               init_busy,
   output logic               push,
   output cisph_pkg::cmd_type push_cmd
);

   localparam int CB = cisph_pkg::CORNER_BITS;
   localparam int BB = cisph_pkg::BIN_BITS;
   localparam logic [CB-1:0] VAL_MASK =
      (VALUE_BITS >= CB) ? {CB{1'b1}} : CB'((1 << VALUE_BITS) - 1);
   localparam logic [BB-1:0] BIN_CAP =
      (NUM_BINS >= (1 << BB)) ? {BB{1'b1}} : BB'(NUM_BINS);
   localparam bit CAP_ON = (NUM_BINS < (1 << BB));

   logic [CB-1:0] corner [8];
   logic [CB-1:0] lo;
   logic [CB-1:0] hi;
   logic [BB-1:0] hi_eff;
   logic          keep;

   assign corner[0] = req_if.corner_a & VAL_MASK;
   assign corner[1] = req_if.corner_b & VAL_MASK;
   assign corner[2] = req_if.corner_c & VAL_MASK;
   assign corner[3] = req_if.corner_d & VAL_MASK;
   assign corner[4] = req_if.corner_e & VAL_MASK;
   assign corner[5] = req_if.corner_f & VAL_MASK;
   assign corner[6] = req_if.corner_g & VAL_MASK;
   assign corner[7] = req_if.corner_h & VAL_MASK;

   always_comb begin
      lo = corner[0];
      hi = corner[0];
      for (int k = 1; k < 8; k++) begin
         if (corner[k] < lo) lo = corner[k];
         if (corner[k] > hi) hi = corner[k];
      end
   end

   // span end clipped to the top of the store
   assign hi_eff = (CAP_ON && (BB'(hi) > BIN_CAP)) ? BIN_CAP : BB'(hi);

   always_comb begin
      case (req_if.operation)
         cisph_pkg::OP_ADD:   keep = (BB'(lo) < hi_eff);
         cisph_pkg::OP_READ:  keep = 1'b1;
         cisph_pkg::OP_CLEAR: keep = 1'b1;
         default:             keep = 1'b0;
      endcase
   end

   assign req_if.ready    = !init_busy && !q_full;
   assign push            = req_if.valid && req_if.ready && keep;
   assign push_cmd.op     = req_if.operation;
   assign push_cmd.lo     = BB'(lo);
   assign push_cmd.hi     = hi_eff;
   assign push_cmd.sel    = req_if.bin_select;
   assign push_cmd.sel_ok = (32'(req_if.bin_select) < 32'(NUM_BINS));

endmodule

[src/cisph_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cisph_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module cisph_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  cisph_pkg::cmd_type push_cmd,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output cisph_pkg::cmd_type head
);

   localparam int DEPTH = cisph_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cisph_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[src/cisph_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cisph_back
// sequencer over the count store: span increments, reads and clearing sweeps
// ----------------------------------------------------------------------------
module cisph_back #(
   parameter int NUM_BINS   = cisph_pkg::NUM_BINS_DEF,
   parameter int COUNT_BITS = cisph_pkg::COUNT_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        empty,
   input  cisph_pkg::cmd_type          head,
   output logic                        pop,
   output logic                        init_busy,
   output logic                        wr_en,
   output logic [$clog2(NUM_BINS)-1:0] wr_addr,
   output logic [COUNT_BITS-1:0]       wr_data,
   output logic [$clog2(NUM_BINS)-1:0] rd_addr,
   input  logic [COUNT_BITS-1:0]       rd_data,
   cisph_rsp_if.source                 rsp_if
);

   localparam int AW = $clog2(NUM_BINS);
   localparam int BB = cisph_pkg::BIN_BITS;
   localparam int OB = cisph_pkg::OUT_COUNT_BITS;

   cisph_pkg::back_state_type state_ff, state_in;
   logic [BB-1:0] cur_ff, cur_in;
   logic [BB-1:0] hi_ff, hi_in;
   logic [BB-1:0] sel_ff, sel_in;
   logic          sel_ok_ff, sel_ok_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic          init_ff, init_in;
   logic          wr_pend_ff, wr_pend_in;
   logic [AW-1:0] wr_addr_ff, wr_addr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [BB-1:0] rsp_bin_ff, rsp_bin_in;
   logic [OB-1:0] rsp_count_ff, rsp_count_in;

   logic          clr_last;
   logic          add_last;
   logic          load_rsp;
   logic [63:0]   cnt_wide;

   assign clr_last = (clr_addr_ff == AW'(NUM_BINS - 1));
   assign add_last = ((cur_ff + 1'b1) == hi_ff);
   assign cnt_wide = 64'(rd_data);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cisph_pkg::BK_CLEAR: begin
            if (clr_last) state_in = cisph_pkg::BK_IDLE;
         end
         cisph_pkg::BK_IDLE: begin
            if (!empty) begin
               case (head.op)
                  cisph_pkg::OP_ADD:   state_in = cisph_pkg::BK_ADD;
                  cisph_pkg::OP_READ:  state_in = cisph_pkg::BK_READ;
                  cisph_pkg::OP_CLEAR: state_in = cisph_pkg::BK_CLEAR;
                  default:             state_in = cisph_pkg::BK_IDLE;
               endcase
            end
         end
         cisph_pkg::BK_ADD: begin
            if (add_last) state_in = cisph_pkg::BK_IDLE;
         end
         cisph_pkg::BK_READ: begin
            state_in = cisph_pkg::BK_RESULT;
         end
         cisph_pkg::BK_RESULT: begin
            if (load_rsp) state_in = cisph_pkg::BK_IDLE;
         end
         default: begin
            state_in = cisph_pkg::BK_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      pop      = 1'b0;
      load_rsp = 1'b0;
      rd_addr  = AW'(cur_ff);
      wr_en    = wr_pend_ff;
      wr_addr  = wr_addr_ff;
      wr_data  = (rd_data == {COUNT_BITS{1'b1}}) ? rd_data : rd_data + 1'b1;
      case (state_ff)
         cisph_pkg::BK_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_ff;
            wr_data = '0;
         end
         cisph_pkg::BK_IDLE: begin
            pop = !empty;
         end
         cisph_pkg::BK_READ: begin
            rd_addr = AW'(sel_ff);
         end
         cisph_pkg::BK_RESULT: begin
            rd_addr  = AW'(sel_ff);
            load_rsp = !rsp_valid_ff || rsp_if.ready;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      cur_in       = cur_ff;
      hi_in        = hi_ff;
      sel_in       = sel_ff;
      sel_ok_in    = sel_ok_ff;
      clr_addr_in  = clr_addr_ff;
      init_in      = init_ff;
      wr_pend_in   = (state_ff == cisph_pkg::BK_ADD);
      wr_addr_in   = AW'(cur_ff);
      rsp_valid_in = rsp_valid_ff;
      rsp_bin_in   = rsp_bin_ff;
      rsp_count_in = rsp_count_ff;

      if (pop) begin
         cur_in      = head.lo;
         hi_in       = head.hi;
         sel_in      = head.sel;
         sel_ok_in   = head.sel_ok;
         clr_addr_in = '0;
      end
      if (state_ff == cisph_pkg::BK_CLEAR) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_last) init_in = 1'b0;
      end
      if (state_ff == cisph_pkg::BK_ADD) begin
         cur_in = cur_ff + 1'b1;
      end

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_bin_in   = sel_ff;
         if (!sel_ok_ff) begin
            rsp_count_in = '0;
         end else if (|cnt_wide[63:OB]) begin
            rsp_count_in = {OB{1'b1}};
         end else begin
            rsp_count_in = cnt_wide[OB-1:0];
         end
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cisph_pkg::BK_CLEAR;
         clr_addr_ff  <= '0;
         init_ff      <= 1'b1;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         init_ff      <= init_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      hi_ff        <= hi_in;
      sel_ff       <= sel_in;
      sel_ok_ff    <= sel_ok_in;
      wr_addr_ff   <= wr_addr_in;
      rsp_bin_ff   <= rsp_bin_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign init_busy         = init_ff;
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.bin_number = rsp_bin_ff;
   assign rsp_if.bin_count  = rsp_count_ff;

endmodule

[src/cube_isovalue_span_histogram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cube_isovalue_span_histogram
// counts per isovalue bin the cubes whose corner span crosses that bin
// ----------------------------------------------------------------------------
// an add walks its span in the back end, one bin per cycle through
// the single write port of the count ram; a read ends in one rsp beat
// a clear sweeps every address of the ram; flat cubes and unused codes are dropped at the front
// commands queue behind the back end, so req beats are taken while it works and the queue is not full
// after reset the ram is cleared with req ready held low
// ----------------------------------------------------------------------------
module cube_isovalue_span_histogram #(
   parameter int VALUE_BITS = cisph_pkg::VALUE_BITS_DEF,
   parameter int NUM_BINS   = cisph_pkg::NUM_BINS_DEF,
   parameter int COUNT_BITS = cisph_pkg::COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   cisph_req_if.sink   req_if,
   cisph_rsp_if.source rsp_if
);

   localparam int AW = $clog2(NUM_BINS);

   logic               q_full;
   logic               q_empty;
   logic               push;
   logic               pop;
   logic               init_busy;
   cisph_pkg::cmd_type push_cmd;
   cisph_pkg::cmd_type head;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [COUNT_BITS-1:0] wr_data;
   logic [AW-1:0]      rd_addr;
   logic [COUNT_BITS-1:0] rd_data;

   cisph_front #(
      .VALUE_BITS (VALUE_BITS),
      .NUM_BINS   (NUM_BINS)
   ) u_front (
      .req_if    (req_if),
      .q_full    (q_full),
      .init_busy (init_busy),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   cisph_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .empty    (q_empty),
      .head     (head)
   );

   cisph_back #(
      .NUM_BINS   (NUM_BINS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (q_empty),
      .head      (head),
      .pop       (pop),
      .init_busy (init_busy),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rsp_if    (rsp_if)
   );

   cisph_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (NUM_BINS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule
